@@ hdl/fpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants of the FIFO page pool tag store.
// ----------------------------------------------------------------------------
package fpp_pkg;

  // access kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_TRIM  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_UPDATE,
    ST_SH_RD,
    ST_SH_WR,
    ST_RESP
  } state_t;

  // result flags handed from the sequencer to the output stage
  typedef struct packed {
    logic evicted;
    logic hit;
  } res_flags_t;

  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;
  localparam int MISS_W      = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

endpackage

@@ hdl/fpp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fpp_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_cfg
// APB register file holding the pool capacity.
// ----------------------------------------------------------------------------
module fpp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fpp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fpp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [fpp_pkg::CAP_W-1:0]        pool_capacity
);
  import fpp_pkg::*;

  // bit 2 of the byte address selects the word; only word 0 exists
  logic sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = ~paddr[APB_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_capacity <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready && sel_cap) begin
      pool_capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = sel_cap ? APB_DATA_W'(pool_capacity) : '0;

endmodule

@@ hdl/fpp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_ctrl
// Sequencer of the tag store: scans the ring of keys through one comparator,
// appends, evicts and compacts entries one RAM access per step.
// ----------------------------------------------------------------------------
module fpp_ctrl #(
  parameter int POOL_DEPTH = 16,
  parameter int KEY_BITS   = 24,
  parameter int CW         = $clog2(POOL_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fpp_pkg::mode_t              in_mode,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic [fpp_pkg::CAP_W-1:0]   cap_raw,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fpp_pkg::res_flags_t         res_flags,
  output logic [KEY_BITS-1:0]         res_key,
  output logic [CW-1:0]               res_count,
  output logic [fpp_pkg::MISS_W-1:0]  res_misses
);
  import fpp_pkg::*;

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(POOL_DEPTH);
  localparam logic [MW-1:0] DEPTH_M = MW'(POOL_DEPTH);

  state_t              state, state_next;
  mode_t               mode;
  logic [KEY_BITS-1:0] key;
  logic [CW-1:0]       cap;
  logic [CW-1:0]       count;
  logic [AW-1:0]       head;
  logic [MISS_W-1:0]   misses;
  logic [CW-1:0]       rd_idx, cmp_idx, pos, j;
  logic                cmp_v, found;
  logic [KEY_BITS-1:0] oldest;
  res_flags_t          flags;
  logic [KEY_BITS-1:0] ev_key;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0] ram_wdata, ram_q;
  logic                rd_issue;
  logic [CW-1:0]       rd_pos;
  logic                match;
  logic [MW-1:0]       cap_ext;
  logic [CW-1:0]       cap_eff;
  logic                last_cmp, sh_done;

  // ring position to RAM address; the sum is always below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= DEPTH_A) ? s - DEPTH_A : s;
    return t[AW-1:0];
  endfunction

  fpp_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // capacity of zero acts as one, above the depth acts as the depth
  always_comb begin
    cap_ext = MW'(cap_raw);
    if (cap_ext == '0) begin
      cap_ext = MW'(1);
    end else if (cap_ext > DEPTH_M) begin
      cap_ext = DEPTH_M;
    end
    cap_eff = cap_ext[CW-1:0];
  end

  assign match     = (ram_q == key);
  assign last_cmp  = ((CW + 1)'(cmp_idx) + (CW + 1)'(1)) == (CW + 1)'(count);
  assign sh_done   = ((CW + 1)'(j) + (CW + 1)'(2)) == (CW + 1)'(count);
  assign ram_raddr = wrap((AW + 1)'(head) + (AW + 1)'(rd_pos));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = wrap((AW + 1)'(head) + (AW + 1)'(count));
    ram_wdata  = key;
    rd_issue   = 1'b0;
    rd_pos     = rd_idx;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mode == MODE_CLEAR || mode == MODE_TRIM) begin
          state_next = ST_RESP;
        end else if (count == '0) begin
          state_next = ST_UPDATE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_issue = (rd_idx < count);
        if (cmp_v && (match || last_cmp)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (mode == MODE_READ && !found) begin
          // slot after the newest; it is the freed oldest one only when every slot is in use
          ram_we     = 1'b1;
          state_next = ST_RESP;
        end else if (mode == MODE_WRITE && found &&
                     ((CW + 1)'(pos) + (CW + 1)'(1)) != (CW + 1)'(count)) begin
          state_next = ST_SH_RD;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_SH_RD: begin
        rd_issue   = 1'b1;
        rd_pos     = j + CW'(1);
        state_next = ST_SH_WR;
      end
      ST_SH_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = wrap((AW + 1)'(head) + (AW + 1)'(j));
        ram_wdata  = ram_q;
        state_next = sh_done ? ST_RESP : ST_SH_RD;
      end
      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      head   <= '0;
      misses <= '0;
      cmp_v  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode <= in_mode;
            key  <= in_key;
            cap  <= cap_eff;
          end
        end
        ST_EXEC: begin
          flags  <= '0;
          ev_key <= '0;
          found  <= 1'b0;
          rd_idx <= '0;
          cmp_v  <= 1'b0;
          if (mode == MODE_CLEAR) begin
            count <= '0;
          end else if (mode == MODE_TRIM && count > cap) begin
            head  <= wrap((AW + 1)'(head) + (AW + 1)'(count - cap));
            count <= cap;
          end
        end
        ST_SCAN: begin
          if (rd_issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          cmp_v   <= rd_issue;
          cmp_idx <= rd_idx;
          if (cmp_v && cmp_idx == '0) begin
            oldest <= ram_q;
          end
          if (cmp_v && match) begin
            found <= 1'b1;
            pos   <= cmp_idx;
          end
        end
        ST_UPDATE: begin
          if (mode == MODE_READ) begin
            if (found) begin
              flags.hit <= 1'b1;
            end else begin
              if (misses != '1) begin
                misses <= misses + MISS_W'(1);
              end
              if (count >= cap) begin
                // drop oldest and append newest: occupancy unchanged
                flags.evicted <= 1'b1;
                ev_key        <= oldest;
                head          <= wrap((AW + 1)'(head) + (AW + 1)'(1));
              end else begin
                count <= count + CW'(1);
              end
            end
          end else if (found) begin
            flags.hit <= 1'b1;
            j         <= pos;
            if (((CW + 1)'(pos) + (CW + 1)'(1)) == (CW + 1)'(count)) begin
              count <= count - CW'(1);
            end
          end
        end
        ST_SH_WR: begin
          if (sh_done) begin
            count <= count - CW'(1);
          end else begin
            j <= j + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign res_flags  = flags;
  assign res_key    = ev_key;
  assign res_count  = count;
  assign res_misses = misses;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(POOL_DEPTH))
    else $error("occupancy above pool depth");

  a_miss_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> misses >= $past(misses))
    else $error("miss counter went backwards");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && mode == MODE_READ) |-> count != '0)
    else $error("pool empty after read access");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && mode == MODE_CLEAR) |-> count == '0)
    else $error("pool not empty after clear");

  a_trim_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && mode == MODE_TRIM) |-> count <= cap)
    else $error("pool above capacity after trim");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && flags.evicted) |-> (mode == MODE_READ && !flags.hit))
    else $error("eviction outside a read miss");

endmodule

@@ hdl/fifo_page_pool_tags_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_pool_tags_top
// Tag store of a fully associative page pool with FIFO replacement.
// ----------------------------------------------------------------------------
// Each input item carries a mode on s_tuser and a key (table id, page index)
// on s_tdata; each item yields exactly one result item on the m_ side with
// hit/evicted flags, the evicted key, the occupancy and the miss counter.
// One item is worked at a time; s_tready is high only while the sequencer is
// idle. The keys sit in a ring buffer RAM read through one comparator:
//   clear, trim            : no scan, straight from accept to result
//   read/write, n resident : a scan of up to n keys (one key compared per cycle)
//   write hit at position p: the scan, then each key after p moved down one slot
// A finished result waits in the output register; while m_tready is low the
// next item can be taken and worked, and its result is held in the sequencer
// until the register frees.
// Reset empties the pool, clears the miss counter and sets the capacity to
// 16; the RAM needs no clearing pass. The capacity register (APB address 0)
// must be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module fifo_page_pool_tags_top #(
  parameter int POOL_DEPTH = 16,
  parameter int TABLE_BITS = 8,
  parameter int PAGE_BITS  = 16,
  parameter int KW         = TABLE_BITS + PAGE_BITS,
  parameter int CW         = $clog2(POOL_DEPTH + 1),
  parameter int IN_W       = ((KW + 7) / 8) * 8,
  parameter int OUT_W      = ((KW + CW + 32 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [IN_W-1:0]                 s_tdata,  // table_id, page_index
  input  logic [1:0]                      s_tuser,  // mode
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_W-1:0]                m_tdata,  // evicted_table, evicted_page,
                                                    // occupancy, miss_count
  output logic [1:0]                      m_tuser,  // hit, evicted
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fpp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fpp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import fpp_pkg::*;

  logic [CAP_W-1:0]  pool_capacity;
  logic [KW-1:0]     in_key;
  logic              res_valid, res_ready;
  res_flags_t        res_flags;
  logic [KW-1:0]     res_key;
  logic [CW-1:0]     res_count;
  logic [MISS_W-1:0] res_misses;

  // key is table id above page index
  assign in_key = {s_tdata[TABLE_BITS-1:0], s_tdata[TABLE_BITS +: PAGE_BITS]};

  fpp_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pool_capacity (pool_capacity)
  );

  fpp_ctrl #(.POOL_DEPTH(POOL_DEPTH), .KEY_BITS(KW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (mode_t'(s_tuser)),
    .in_key     (in_key),
    .cap_raw    (pool_capacity),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_flags  (res_flags),
    .res_key    (res_key),
    .res_count  (res_count),
    .res_misses (res_misses)
  );

  assign res_ready = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= OUT_W'({res_misses, res_count,
                         res_key[PAGE_BITS-1:0], res_key[KW-1:PAGE_BITS]});
      m_tuser <= {res_flags.evicted, res_flags.hit};
    end
  end

endmodule

@@ tb/fifo_page_pool_tags_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_pool_tags_top_test
// Self-checking bench for the FIFO page pool tag store.
// ----------------------------------------------------------------------------
// A clocked driver sends queued accesses in random bursts. Each accepted item
// is run through a local FIFO-replacement pool model, which queues the
// expected lookup result. A clocked monitor stalls on its own pattern and
// checks every returned item field by field. The capacity register is
// reprogrammed between phases while the pool is idle. Directed accesses come
// first: key extremes, every mode, eviction, over-capacity misses, trim,
// clear and writes that miss. Random phases follow, at capacities that
// include 0, 1, 16, 17 and 31.
// ----------------------------------------------------------------------------
module fifo_page_pool_tags_top_test;
  import fpp_pkg::*;

  localparam int POOL_SLOTS  = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR   = 3'd0;
  // next word slot; no register lives there
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  tbl;
    logic [15:0] pg;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [7:0]  ev_tbl;
    logic [15:0] ev_pg;
    logic [4:0]  occ;
    logic [31:0] misses;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata  = '0;  // table_id, page_index
  logic [1:0]            s_tuser  = MODE_READ;  // mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;  // evicted_table, evicted_page, occupancy, miss_count
  logic [1:0]            m_tuser;  // hit, evicted
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fifo_page_pool_tags_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // pool model state
  logic [23:0] pool_keys [POOL_SLOTS];
  int          pool_fill  = 0;
  logic [31:0] miss_tally = '0;
  logic [4:0]  cap_reg    = 5'(CAP_RESET);

  access_t     pending_access [$];
  lookup_res_t expected_lookups [$];

  int mismatch_cnt    = 0;
  int results_checked = 0;
  int clk_cycles      = 0;
  int n_hits = 0, n_misses = 0, n_evictions = 0, n_removals = 0;
  int n_clears = 0, n_trims = 0, n_settings = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
               results_checked, what, want, got);
  endtask

  task automatic cmp_field(input string what, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  // remove one entry and close the gap, keeping age order
  task automatic drop_entry(input int at);
    int i;
    for (i = at; i + 1 < pool_fill; i++) pool_keys[i] = pool_keys[i + 1];
    pool_fill--;
  endtask

  task automatic predict_lookup(input mode_t m, input logic [7:0] tbl,
                                input logic [15:0] pg);
    lookup_res_t r;
    logic [23:0] key;
    int pos;
    int lim;
    int i;
    r   = '0;
    key = {tbl, pg};
    lim = (cap_reg == 0) ? 1 : ((cap_reg > POOL_SLOTS) ? POOL_SLOTS : int'(cap_reg));
    pos = -1;
    // scan downward so the oldest match wins
    for (i = pool_fill - 1; i >= 0; i--) if (pool_keys[i] == key) pos = i;
    case (m)
      MODE_READ: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
          n_hits++;
        end else begin
          n_misses++;
          if (miss_tally != '1) miss_tally++;
          // over capacity still drops only the single oldest entry
          if (pool_fill >= lim && pool_fill > 0) begin
            r.evicted         = 1'b1;
            {r.ev_tbl, r.ev_pg} = pool_keys[0];
            drop_entry(0);
            n_evictions++;
          end
          if (pool_fill < POOL_SLOTS) begin
            pool_keys[pool_fill] = key;
            pool_fill++;
          end
        end
      end
      MODE_WRITE: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
          drop_entry(pos);
          n_removals++;
        end
      end
      MODE_CLEAR: begin
        pool_fill = 0;
        n_clears++;
      end
      default: begin
        if (pool_fill > lim) n_trims++;
        while (pool_fill > lim) drop_entry(0);
      end
    endcase
    r.occ    = 5'(pool_fill);
    r.misses = miss_tally;
    expected_lookups.insert(expected_lookups.size(), r);
  endtask

  task automatic check_lookup(input lookup_res_t e);
    results_checked++;
    cmp_field("hit", e.hit, m_tuser[0]);
    cmp_field("evicted", e.evicted, m_tuser[1]);
    cmp_field("evicted_table", e.ev_tbl, m_tdata[7:0]);
    cmp_field("evicted_page", e.ev_pg, m_tdata[23:8]);
    cmp_field("occupancy", e.occ, m_tdata[28:24]);
    cmp_field("miss_count", e.misses, m_tdata[60:29]);
    cmp_field("tdata padding", 0, m_tdata[63:61]);
  endtask

  // driver: bursts of random length, random gaps between them
  access_t drv_item;
  int      burst_left = 0;
  int      gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_lookup(mode_t'(s_tuser), s_tdata[7:0], s_tdata[23:8]);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_access.size() != 0) begin
          drv_item = pending_access[0];
          pending_access.delete(0);
          s_tvalid <= 1'b1;
          s_tdata  <= {drv_item.pg, drv_item.tbl};
          s_tuser  <= drv_item.mode;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stall pattern changes whenever its random span runs out
  int stall_kind = 0;
  int stall_span = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("item with nothing pending", 0, m_tdata[31:0]);
        end else begin
          check_lookup(expected_lookups[0]);
          expected_lookups.delete(0);
        end
      end
      if (stall_span == 0) begin
        stall_kind <= $urandom_range(0, 3);
        stall_span <= $urandom_range(50, 400);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_kind)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (clk_cycles % 7) < 2;
        default: m_tready <= ((clk_cycles / 16) % 3) == 0;  // long stalls
      endcase
    end
  end

  always @(posedge clk) begin
    clk_cycles <= clk_cycles + 1;
    if (clk_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", clk_cycles,
               expected_lookups.size() + pending_access.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity_reg();
    logic [31:0] rd;
    apb_read(CAP_ADDR, rd);
    cmp_field("pool_capacity readback", {27'd0, cap_reg}, rd);
  endtask

  // only bits [4:0] count; also poke the empty slot, which must be ignored
  task automatic program_capacity(input logic [4:0] cap);
    apb_write(CAP_ADDR, ($urandom & ~32'h1f) | cap);
    cap_reg = cap;
    apb_write(SPARE_ADDR, $urandom);
    check_capacity_reg();
    n_settings++;
  endtask

  task automatic queue_access(input mode_t m, input logic [7:0] tbl, input logic [15:0] pg);
    access_t a;
    a.mode = m;
    a.tbl  = tbl;
    a.pg   = pg;
    pending_access.insert(pending_access.size(), a);
  endtask

  // wait until every item has been sent and answered
  task automatic settle_pool();
    while (pending_access.size() != 0 || s_tvalid || expected_lookups.size() != 0)
      @(posedge clk);
  endtask

  // mostly a small working set of keys so reads hit and the pool fills
  task automatic queue_random_phase(input int count);
    logic [23:0] hot_keys [24];
    logic [23:0] k;
    int hot_n;
    int pick;
    int i;
    mode_t m;
    hot_n = $urandom_range(3, 24);
    for (i = 0; i < hot_n; i++) hot_keys[i] = 24'($urandom);
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      m = (pick < 66) ? MODE_READ : (pick < 90) ? MODE_WRITE :
          (pick < 92) ? MODE_CLEAR : MODE_TRIM;
      if ($urandom_range(0, 3) != 0) k = hot_keys[$urandom_range(0, hot_n - 1)];
      else k = 24'($urandom);
      queue_access(m, k[23:16], k[15:0]);
    end
  endtask

  initial begin
    logic [4:0] caps [9];
    int p;
    caps = '{5'd0, 5'd16, 5'd4, 5'd31, 5'd1, 5'd17, 5'($urandom_range(5, 15)), 5'd2,
             5'($urandom_range(0, 31))};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    check_capacity_reg();

    // small pool: fill, evict, hit, remove from the middle
    program_capacity(5'd3);
    queue_access(MODE_READ,  8'h00, 16'h0000);
    queue_access(MODE_READ,  8'hff, 16'hffff);
    queue_access(MODE_READ,  8'h00, 16'h0000);
    queue_access(MODE_READ,  8'h5a, 16'ha5a5);
    queue_access(MODE_READ,  8'ha5, 16'h5a5a);
    queue_access(MODE_WRITE, 8'h5a, 16'ha5a5);
    queue_access(MODE_WRITE, 8'h01, 16'h0001);
    queue_access(MODE_READ,  8'h12, 16'h3456);
    queue_access(MODE_READ,  8'h00, 16'hffff);
    queue_access(MODE_TRIM,  8'hff, 16'hffff);
    queue_access(MODE_CLEAR, 8'hff, 16'hffff);
    queue_access(MODE_WRITE, 8'hff, 16'hffff);
    queue_access(MODE_READ,  8'hff, 16'h0000);
    queue_access(MODE_READ,  8'h00, 16'hffff);
    queue_access(MODE_READ,  8'h7f, 16'h8000);
    settle_pool();

    // capacity below occupancy: miss keeps occupancy, trim cuts down
    program_capacity(5'd1);
    queue_access(MODE_READ,  8'h80, 16'h0001);
    queue_access(MODE_TRIM,  8'h00, 16'h0000);
    queue_access(MODE_READ,  8'h80, 16'h0001);
    queue_access(MODE_TRIM,  8'h00, 16'h0000);
    queue_access(MODE_CLEAR, 8'h00, 16'h0000);
    queue_access(MODE_TRIM,  8'h00, 16'h0000);
    queue_access(MODE_WRITE, 8'h80, 16'h0001);
    queue_access(MODE_READ,  8'h00, 16'h0000);
    queue_access(MODE_READ,  8'hff, 16'hffff);
    settle_pool();

    for (p = 0; p < 9; p++) begin
      program_capacity(caps[p]);
      queue_random_phase(169);
      settle_pool();
    end

    repeat (60) @(posedge clk);
    if (expected_lookups.size() != 0)
      report_mismatch("results never returned", 0, expected_lookups.size());
    $display("%0d items checked at %0d capacity settings: %0d read hits, %0d misses,",
             results_checked, n_settings, n_hits, n_misses);
    $display("%0d evictions, %0d write removals, %0d clears, %0d trims that dropped entries",
             n_evictions, n_removals, n_clears, n_trims);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fpp_pkg.sv
hdl/fpp_ram.sv
hdl/fpp_cfg.sv
hdl/fpp_ctrl.sv
hdl/fifo_page_pool_tags_top.sv
tb/fifo_page_pool_tags_top_test.sv
